### sv/rbc_pkg.sv
package rbc_pkg;

    localparam int ENTRIES     = 32;
    localparam int HANDLE_BITS = 16;
    localparam int ADDR_BITS   = 32;
    localparam int IDX_W       = $clog2(ENTRIES);
    localparam int CNT_W       = $clog2(ENTRIES + 1);

    typedef enum logic [0:0] {
        ACT_LOOKUP = 1'b0,
        ACT_ADD    = 1'b1
    } action_t;

    typedef enum logic [1:0] {
        KIND_LOOKUP = 2'd0,
        KIND_FREED  = 2'd1,
        KIND_ADDED  = 2'd2
    } kind_t;

    typedef struct packed {
        logic [ADDR_BITS-1:0]   rng_start;
        logic [ADDR_BITS-1:0]   rng_end;
        logic [ADDR_BITS-1:0]   base;
        logic [HANDLE_BITS-1:0] handle;
    } entry_t;

    localparam int ENTRY_W = $bits(entry_t);

endpackage

### sv/rbc_ram.sv
module rbc_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 32
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

### sv/range_buffer_cache.sv
// Fully associative cache of address ranges with handle and base offset. A request is taken
// when start is high and busy is low. Results come out at most one per cycle on result_strobe
// and cannot be held off; last marks the final one of a request. The table sits in one RAM
// whose single read port is walked one entry per cycle, so a lookup keeps busy high through
// the walk up to its lowest hit, or the whole walk on a miss; an add walks the whole table,
// then reads and evicts the victim entry when the table is full after its frees. Inside-range
// frees of an add come out during the walk, one per matching entry in ascending order.
module range_buffer_cache
    import rbc_pkg::*;
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   start,
    output logic                   busy,
    input  logic                   action,
    input  logic [ADDR_BITS-1:0]   start_addr,
    input  logic [ADDR_BITS-1:0]   length,
    input  logic [HANDLE_BITS-1:0] handle,
    input  logic [ADDR_BITS-1:0]   base_offset,
    output logic                   result_strobe,
    output logic [1:0]             kind,
    output logic                   hit,
    output logic [HANDLE_BITS-1:0] result_handle,
    output logic [ADDR_BITS-1:0]   result_offset,
    output logic                   last
);

    typedef enum logic [6:0] {
        S_IDLE   = 7'b0000001,
        S_LSCAN  = 7'b0000010,
        S_LRES   = 7'b0000100,
        S_ASCAN  = 7'b0001000,
        S_AEVRD  = 7'b0010000,
        S_AEVICT = 7'b0100000,
        S_AWRITE = 7'b1000000
    } state_t;

    state_t state_reg, state_next;

    logic [ENTRIES-1:0]     valid_reg, valid_next;
    logic [CNT_W-1:0]       used_reg, used_next;
    logic [IDX_W-1:0]       victim_reg, victim_next;
    logic [CNT_W-1:0]       idx_reg, idx_next;
    logic                   cmp_vld_reg, cmp_vld_next;
    logic [IDX_W-1:0]       cmp_idx_reg, cmp_idx_next;
    logic                   free_found_reg, free_found_next;
    logic [IDX_W-1:0]       slot_reg, slot_next;

    logic [ADDR_BITS-1:0]   req_start_reg, req_start_next;
    logic [ADDR_BITS-1:0]   req_end_reg, req_end_next;
    logic [ADDR_BITS-1:0]   req_base_reg, req_base_next;
    logic [HANDLE_BITS-1:0] req_handle_reg, req_handle_next;

    logic                   hit_reg, hit_next;
    logic [ADDR_BITS-1:0]   hit_start_reg, hit_start_next;
    logic [ADDR_BITS-1:0]   hit_base_reg, hit_base_next;
    logic [HANDLE_BITS-1:0] hit_handle_reg, hit_handle_next;

    logic                   strobe_reg, strobe_next;
    kind_t                  kind_reg, kind_next;
    logic                   hit_out_reg, hit_out_next;
    logic [HANDLE_BITS-1:0] handle_out_reg, handle_out_next;
    logic [ADDR_BITS-1:0]   offset_out_reg, offset_out_next;
    logic                   last_reg, last_next;

    logic                   ram_we;
    logic [IDX_W-1:0]       ram_raddr;
    entry_t                 ram_wdata;
    entry_t                 ram_rdata;

    logic                   issue;
    logic                   scan_last;
    logic [ADDR_BITS-1:0]   cmp_a_lo, cmp_b_lo, cmp_a_hi, cmp_b_hi;
    logic                   contains;
    logic                   match;
    logic [CNT_W-1:0]       used_after;

    rbc_ram #(
        .WIDTH (ENTRY_W),
        .DEPTH (ENTRIES)
    ) u_table (
        .clk   (clk),
        .we    (ram_we),
        .waddr (slot_reg),
        .wdata (ram_wdata),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    assign ram_wdata = '{rng_start: req_start_reg, rng_end: req_end_reg,
                         base: req_base_reg, handle: req_handle_reg};
    assign ram_we    = (state_reg == S_AWRITE);
    assign ram_raddr = (state_reg == S_AEVRD) ? slot_reg : idx_reg[IDX_W-1:0];
    assign issue     = (idx_reg < CNT_W'(ENTRIES));
    assign scan_last = cmp_vld_reg && (cmp_idx_reg == IDX_W'(ENTRIES - 1));

    // Shared containment compare: query inside entry for lookup, entry inside query for add
    always_comb
    begin
        if (state_reg == S_LSCAN)
        begin
            cmp_a_lo = req_start_reg;
            cmp_b_lo = ram_rdata.rng_start;
            cmp_a_hi = ram_rdata.rng_end;
            cmp_b_hi = req_end_reg;
        end
        else
        begin
            cmp_a_lo = ram_rdata.rng_start;
            cmp_b_lo = req_start_reg;
            cmp_a_hi = req_end_reg;
            cmp_b_hi = ram_rdata.rng_end;
        end
    end

    assign contains   = (cmp_a_lo >= cmp_b_lo) && (cmp_a_hi >= cmp_b_hi);
    assign match      = cmp_vld_reg && valid_reg[cmp_idx_reg] && contains;
    assign used_after = used_reg - CNT_W'(match);

    always_comb
    begin
        state_next      = state_reg;
        valid_next      = valid_reg;
        used_next       = used_reg;
        victim_next     = victim_reg;
        idx_next        = idx_reg;
        cmp_vld_next    = 1'b0;
        cmp_idx_next    = cmp_idx_reg;
        free_found_next = free_found_reg;
        slot_next       = slot_reg;
        req_start_next  = req_start_reg;
        req_end_next    = req_end_reg;
        req_base_next   = req_base_reg;
        req_handle_next = req_handle_reg;
        hit_next        = hit_reg;
        hit_start_next  = hit_start_reg;
        hit_base_next   = hit_base_reg;
        hit_handle_next = hit_handle_reg;
        strobe_next     = 1'b0;
        kind_next       = kind_reg;
        hit_out_next    = hit_out_reg;
        handle_out_next = handle_out_reg;
        offset_out_next = offset_out_reg;
        last_next       = last_reg;

        case (state_reg)
            S_IDLE:
            begin
                if (start)
                begin
                    req_start_next  = start_addr;
                    req_end_next    = start_addr + length;
                    req_base_next   = base_offset;
                    req_handle_next = handle;
                    idx_next        = '0;
                    hit_next        = 1'b0;
                    free_found_next = 1'b0;
                    if (action == ACT_LOOKUP)
                    begin
                        victim_next = (victim_reg == IDX_W'(ENTRIES - 1)) ? '0
                                                                          : victim_reg + 1'b1;
                        state_next  = S_LSCAN;
                    end
                    else
                    begin
                        state_next = S_ASCAN;
                    end
                end
            end

            S_LSCAN:
            begin
                if (issue)
                begin
                    idx_next     = idx_reg + 1'b1;
                    cmp_vld_next = 1'b1;
                    cmp_idx_next = idx_reg[IDX_W-1:0];
                end
                if (match)
                begin
                    // stop at the lowest hit
                    hit_next        = 1'b1;
                    hit_start_next  = ram_rdata.rng_start;
                    hit_base_next   = ram_rdata.base;
                    hit_handle_next = ram_rdata.handle;
                    state_next      = S_LRES;
                end
                else if (scan_last)
                begin
                    state_next = S_LRES;
                end
            end

            S_LRES:
            begin
                strobe_next     = 1'b1;
                kind_next       = KIND_LOOKUP;
                hit_out_next    = hit_reg;
                handle_out_next = hit_reg ? hit_handle_reg : '0;
                offset_out_next = hit_reg ? (req_start_reg - hit_start_reg) + hit_base_reg
                                          : '0;
                last_next       = 1'b1;
                state_next      = S_IDLE;
            end

            S_ASCAN:
            begin
                if (issue)
                begin
                    idx_next     = idx_reg + 1'b1;
                    cmp_vld_next = 1'b1;
                    cmp_idx_next = idx_reg[IDX_W-1:0];
                end
                if (match)
                begin
                    valid_next[cmp_idx_reg] = 1'b0;
                    used_next               = used_after;
                    strobe_next             = 1'b1;
                    kind_next               = KIND_FREED;
                    hit_out_next            = 1'b0;
                    handle_out_next         = ram_rdata.handle;
                    offset_out_next         = '0;
                    last_next               = 1'b0;
                end
                // remember the lowest slot left free after the frees
                if (cmp_vld_reg && !free_found_reg && (match || !valid_reg[cmp_idx_reg]))
                begin
                    free_found_next = 1'b1;
                    slot_next       = cmp_idx_reg;
                end
                if (scan_last)
                begin
                    if (used_after == CNT_W'(ENTRIES))
                    begin
                        slot_next  = victim_reg;
                        state_next = S_AEVRD;
                    end
                    else
                    begin
                        state_next = S_AWRITE;
                    end
                end
            end

            S_AEVRD:
            begin
                state_next = S_AEVICT;
            end

            S_AEVICT:
            begin
                strobe_next     = 1'b1;
                kind_next       = KIND_FREED;
                hit_out_next    = 1'b0;
                handle_out_next = ram_rdata.handle;
                offset_out_next = '0;
                last_next       = 1'b0;
                state_next      = S_AWRITE;
            end

            S_AWRITE:
            begin
                valid_next[slot_reg] = 1'b1;
                if (used_reg < CNT_W'(ENTRIES))
                begin
                    used_next = used_reg + 1'b1;
                end
                strobe_next     = 1'b1;
                kind_next       = KIND_ADDED;
                hit_out_next    = 1'b0;
                handle_out_next = req_handle_reg;
                offset_out_next = '0;
                last_next       = 1'b1;
                state_next      = S_IDLE;
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= S_IDLE;
            valid_reg   <= '0;
            used_reg    <= '0;
            victim_reg  <= '0;
            cmp_vld_reg <= 1'b0;
            strobe_reg  <= 1'b0;
        end
        else
        begin
            state_reg   <= state_next;
            valid_reg   <= valid_next;
            used_reg    <= used_next;
            victim_reg  <= victim_next;
            cmp_vld_reg <= cmp_vld_next;
            strobe_reg  <= strobe_next;
        end
    end

    always_ff @(posedge clk)
    begin
        idx_reg        <= idx_next;
        cmp_idx_reg    <= cmp_idx_next;
        free_found_reg <= free_found_next;
        slot_reg       <= slot_next;
        req_start_reg  <= req_start_next;
        req_end_reg    <= req_end_next;
        req_base_reg   <= req_base_next;
        req_handle_reg <= req_handle_next;
        hit_reg        <= hit_next;
        hit_start_reg  <= hit_start_next;
        hit_base_reg   <= hit_base_next;
        hit_handle_reg <= hit_handle_next;
        kind_reg       <= kind_next;
        hit_out_reg    <= hit_out_next;
        handle_out_reg <= handle_out_next;
        offset_out_reg <= offset_out_next;
        last_reg       <= last_next;
    end

    assign busy          = (state_reg != S_IDLE);
    assign result_strobe = strobe_reg;
    assign kind          = kind_reg;
    assign hit           = hit_out_reg;
    assign result_handle = handle_out_reg;
    assign result_offset = offset_out_reg;
    assign last          = last_reg;

    a_used_matches_valid: assert property (@(posedge clk) disable iff (!rst_n)
        used_reg == CNT_W'($countones(valid_reg)))
        else $error("used count disagrees with valid entries");

    a_last_frees_block: assert property (@(posedge clk) disable iff (!rst_n)
        result_strobe && last |-> !busy)
        else $error("final result shown while still busy");

    a_lookup_single: assert property (@(posedge clk) disable iff (!rst_n)
        result_strobe && (kind == KIND_LOOKUP) |-> last)
        else $error("lookup answer not marked last");

    a_request_taken: assert property (@(posedge clk) disable iff (!rst_n)
        start && !busy |=> busy)
        else $error("request accepted without going busy");

    a_full_evicts: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == S_AEVRD |-> used_reg == CNT_W'(ENTRIES))
        else $error("eviction on a table that is not full");

endmodule

### bench/range_buffer_cache_tb.sv
`timescale 1ns / 100ps

module range_buffer_cache_tb;
    import rbc_pkg::*;

    typedef struct {
        kind_t                  kind;
        logic                   hit;
        logic [HANDLE_BITS-1:0] handle;
        logic [ADDR_BITS-1:0]   offset;
        logic                   last;
    } outcome_t;

    class range_table_tracker;
        bit                     in_use [ENTRIES];
        logic [ADDR_BITS-1:0]   lo_addr [ENTRIES];
        logic [ADDR_BITS-1:0]   hi_addr [ENTRIES];
        logic [ADDR_BITS-1:0]   dev_base [ENTRIES];
        logic [HANDLE_BITS-1:0] buf_handle [ENTRIES];
        int unsigned            used;
        int unsigned            victim;
        outcome_t               awaited [$];
        int unsigned            failures;

        function new();
            for (int i = 0; i < ENTRIES; i++)
            begin
                in_use[i] = 1'b0;
            end
            used = 0;
            victim = 0;
            failures = 0;
        endfunction

        function void push(kind_t k, logic h, logic [HANDLE_BITS-1:0] hd,
                           logic [ADDR_BITS-1:0] off, logic l);
            outcome_t o;
            o.kind = k;
            o.hit = h;
            o.handle = hd;
            o.offset = off;
            o.last = l;
            awaited.push_back(o);
        endfunction

        function void note_request(action_t act, logic [ADDR_BITS-1:0] s,
                                   logic [ADDR_BITS-1:0] len,
                                   logic [HANDLE_BITS-1:0] h,
                                   logic [ADDR_BITS-1:0] b);
            logic [ADDR_BITS-1:0] e;
            int unsigned slot;
            e = s + len;
            if (act == ACT_LOOKUP)
            begin
                victim = (victim + 1) % ENTRIES;
                for (int i = 0; i < ENTRIES; i++)
                begin
                    if (in_use[i] && s >= lo_addr[i] && e <= hi_addr[i])
                    begin
                        push(KIND_LOOKUP, 1'b1, buf_handle[i],
                             (s - lo_addr[i]) + dev_base[i], 1'b1);
                        return;
                    end
                end
                push(KIND_LOOKUP, 1'b0, '0, '0, 1'b1);
                return;
            end
            for (int i = 0; i < ENTRIES; i++)
            begin
                if (in_use[i] && lo_addr[i] >= s && hi_addr[i] <= e)
                begin
                    push(KIND_FREED, 1'b0, buf_handle[i], '0, 1'b0);
                    in_use[i] = 1'b0;
                    if (used > 0)
                        used--;
                end
            end
            slot = 0;
            if (used >= ENTRIES)
            begin
                slot = victim;
                if (in_use[slot])
                begin
                    push(KIND_FREED, 1'b0, buf_handle[slot], '0, 1'b0);
                    in_use[slot] = 1'b0;
                    if (used > 0)
                        used--;
                end
            end
            else
            begin
                for (int i = ENTRIES - 1; i >= 0; i--)
                begin
                    if (!in_use[i])
                        slot = i;
                end
            end
            in_use[slot] = 1'b1;
            lo_addr[slot] = s;
            hi_addr[slot] = e;
            dev_base[slot] = b;
            buf_handle[slot] = h;
            if (used < ENTRIES)
                used++;
            push(KIND_ADDED, 1'b0, h, '0, 1'b1);
        endfunction

        function void check_result(logic [1:0] k, logic h, logic [HANDLE_BITS-1:0] hd,
                                   logic [ADDR_BITS-1:0] off, logic l);
            outcome_t want;
            if (awaited.size() == 0)
            begin
                $error("unexpected result: kind %0d handle 'h%h", k, hd);
                failures++;
                return;
            end
            want = awaited.pop_front();
            if (k !== want.kind)
            begin
                $error("kind: expected %0d, actual %0d", want.kind, k);
                failures++;
            end
            if (h !== want.hit)
            begin
                $error("hit: expected %0d, actual %0d", want.hit, h);
                failures++;
            end
            if (hd !== want.handle)
            begin
                $error("result_handle: expected 'h%h, actual 'h%h", want.handle, hd);
                failures++;
            end
            if (off !== want.offset)
            begin
                $error("result_offset: expected 'h%h, actual 'h%h", want.offset, off);
                failures++;
            end
            if (l !== want.last)
            begin
                $error("last: expected %0d, actual %0d", want.last, l);
                failures++;
            end
        endfunction
    endclass

    logic                   clk = 1'b0;
    logic                   rst_n;
    logic                   start;
    logic                   busy;
    logic                   action;
    logic [ADDR_BITS-1:0]   start_addr;
    logic [ADDR_BITS-1:0]   length;
    logic [HANDLE_BITS-1:0] handle;
    logic [ADDR_BITS-1:0]   base_offset;
    logic                   result_strobe;
    logic [1:0]             kind;
    logic                   hit;
    logic [HANDLE_BITS-1:0] result_handle;
    logic [ADDR_BITS-1:0]   result_offset;
    logic                   last;

    range_table_tracker tracker = new();
    int unsigned        idle_pct;

    range_buffer_cache dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .start         (start),
        .busy          (busy),
        .action        (action),
        .start_addr    (start_addr),
        .length        (length),
        .handle        (handle),
        .base_offset   (base_offset),
        .result_strobe (result_strobe),
        .kind          (kind),
        .hit           (hit),
        .result_handle (result_handle),
        .result_offset (result_offset),
        .last          (last)
    );

    always
    begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    always @(posedge clk)
    begin
        if (rst_n === 1'b1 && result_strobe === 1'b1)
            tracker.check_result(kind, hit, result_handle, result_offset, last);
    end

    task automatic issue(input action_t act, input logic [ADDR_BITS-1:0] s,
                         input logic [ADDR_BITS-1:0] len, input logic [HANDLE_BITS-1:0] h,
                         input logic [ADDR_BITS-1:0] b);
        while ($urandom_range(0, 99) < idle_pct)
        begin
            start <= 1'b0;
            @(negedge clk);
        end
        start <= 1'b1;
        action <= act;
        start_addr <= s;
        length <= len;
        handle <= h;
        base_offset <= b;
        @(posedge clk);
        while (busy !== 1'b0)
            @(posedge clk);
        tracker.note_request(act, s, len, h, b);
        @(negedge clk);
    endtask

    // hold off new requests until every result has come back
    task automatic drain();
        start <= 1'b0;
        while (tracker.awaited.size() != 0)
            @(posedge clk);
        @(negedge clk);
    endtask

    task automatic run_random(input int count);
        logic [ADDR_BITS-1:0] region;
        logic [ADDR_BITS-1:0] span;
        logic [ADDR_BITS-1:0] off;
        int unsigned          r;
        int                   pick;
        int                   live_idx [$];
        region = {12'($urandom_range(0, 12'hFFC)), 20'h0};
        repeat (count)
        begin
            r = $urandom_range(0, 99);
            live_idx.delete();
            for (int i = 0; i < ENTRIES; i++)
            begin
                if (tracker.in_use[i])
                    live_idx.push_back(i);
            end
            if (r < 3)
                drain();
            if (r < 48)
                issue(ACT_ADD, region + $urandom_range(0, 32'h000F_FFFF),
                      $urandom_range(1, 8192), 16'($urandom), $urandom);
            else if (r < 78 && live_idx.size() > 0)
            begin
                // aim inside a live entry
                pick = live_idx[$urandom_range(0, live_idx.size() - 1)];
                span = tracker.hi_addr[pick] - tracker.lo_addr[pick];
                off = $urandom_range(0, span);
                issue(ACT_LOOKUP, tracker.lo_addr[pick] + off,
                      $urandom_range(0, span - off), 16'($urandom), $urandom);
            end
            else if (r < 90)
                issue(ACT_LOOKUP, region + $urandom_range(0, 32'h0010_FFFF),
                      $urandom_range(0, 4096), 16'($urandom), $urandom);
            else if (r < 92)
                issue(ACT_ADD, region + $urandom_range(0, 32'h0008_0000),
                      $urandom_range(32'h0001_0000, 32'h0010_0000), 16'($urandom),
                      $urandom);
            else
                issue(action_t'($urandom_range(0, 1)), $urandom, $urandom, 16'($urandom),
                      $urandom);
        end
    endtask

    initial
    begin
        rst_n = 1'b0;
        start = 1'b0;
        action = ACT_LOOKUP;
        start_addr = '0;
        length = '0;
        handle = '0;
        base_offset = '0;
        idle_pct = 38;
        repeat (10) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        issue(ACT_LOOKUP, 32'h0, 32'h0, 16'h0, 32'h0);
        issue(ACT_ADD, 32'h1000, 32'h1000, 16'hFFFF, 32'hFFFF_FF00);
        issue(ACT_LOOKUP, 32'h1800, 32'h100, 16'h0, 32'h0);
        issue(ACT_LOOKUP, 32'h1000, 32'h1000, 16'h0, 32'h0);
        issue(ACT_LOOKUP, 32'h0FFF, 32'h2, 16'h0, 32'h0);
        // wrapped range
        issue(ACT_ADD, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 16'h0, 32'h0);
        issue(ACT_LOOKUP, 32'hFFFF_FFFF, 32'h0, 16'hFFFF, 32'hFFFF_FFFF);
        // empty range
        issue(ACT_ADD, 32'h2000, 32'h0, 16'h1234, 32'h0);
        issue(ACT_LOOKUP, 32'h2000, 32'h0, 16'h0, 32'h0);
        issue(ACT_ADD, 32'h1000, 32'h1000, 16'hA5A5, 32'h8000_0000);
        issue(ACT_ADD, 32'h1_0000, 32'h800, 16'h0001, 32'h0000_0010);
        issue(ACT_ADD, 32'h1_1000, 32'h800, 16'h0002, 32'h0000_0020);
        issue(ACT_ADD, 32'h1_2000, 32'h800, 16'h0003, 32'h0000_0030);
        issue(ACT_LOOKUP, 32'h1_1400, 32'h400, 16'h0, 32'h0);
        issue(ACT_LOOKUP, 32'h1_1400, 32'h401, 16'h0, 32'h0);
        // sweep the whole table
        issue(ACT_ADD, 32'h0, 32'hFFFF_FFFF, 16'h5A5A, 32'h7FFF_FFFF);
        issue(ACT_LOOKUP, 32'h0, 32'hFFFF_FFFF, 16'h0, 32'h0);
        issue(ACT_ADD, 32'hFFFF_FFFF, 32'h1, 16'hFFFF, 32'hFFFF_FFFF);
        issue(ACT_LOOKUP, 32'h1234_5678, 32'h10, 16'h0, 32'h0);
        issue(ACT_LOOKUP, 32'hFFFF_FFFF, 32'h0, 16'h0, 32'h0);
        drain();

        run_random(54);
        drain();
        idle_pct = 79;
        run_random(54);
        drain();
        idle_pct = 0;
        run_random(54);
        drain();
        repeat (ENTRIES + 4) @(posedge clk);

        if (tracker.failures == 0 && tracker.awaited.size() == 0)
            $display("range_buffer_cache test passed");
        else
            $display("range_buffer_cache test failed");
        $finish;
    end

    initial
    begin
        #2_000_000;
        $display("range_buffer_cache test failed");
        $finish;
    end

endmodule
